@@ sv/hwcc_pkg.sv @@
// Package for the hitbox wall collision check: widths, defaults, register
// indices, opcodes and the controller command struct. No dependencies.
package hwcc_pkg;

  localparam int MAX_WALLS_DEF   = 64;
  localparam int COORD_WIDTH_DEF = 32;
  localparam int FIELD_W         = 31;
  localparam int HALF_W          = 30;
  localparam int COUNT_W         = 7;
  localparam int CFG_W           = 30;
  localparam int CFG_IDX_W       = 1;

  localparam logic [CFG_IDX_W-1:0] REG_HITBOX_HALF = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_WALL_COUNT  = 1'b1;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [HALF_W-1:0] HALF_RESET = 30'd16384;

  // Controller to datapath.
  typedef struct packed {
    logic load_query;
    logic test_step;
  } hwcc_cmd_t;

endpackage

@@ sv/hwcc_ram.sv @@
// Generic dual port RAM with registered read.
// No dependencies.
module hwcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ sv/hwcc_datapath.sv @@
// Datapath: wall table, hitbox registers, one segment test per test cycle.
// Depends on hwcc_pkg and hwcc_ram.
module hwcc_datapath
  import hwcc_pkg::*;
#(
  parameter int MAX_WALLS   = MAX_WALLS_DEF,
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  localparam int AW         = (MAX_WALLS > 1) ? $clog2(MAX_WALLS) : 1
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [5:0]                 wr_index,
  input  logic signed [FIELD_W-1:0]  ax,
  input  logic signed [FIELD_W-1:0]  ay,
  input  logic signed [FIELD_W-1:0]  bx,
  input  logic signed [FIELD_W-1:0]  by,
  input  logic signed [FIELD_W-1:0]  px,
  input  logic signed [FIELD_W-1:0]  py,
  input  logic [HALF_W-1:0]          half,
  input  hwcc_cmd_t                  cmd,
  input  logic [AW-1:0]              rd_addr,
  input  logic [3:0]                 test_sel,
  output logic                       hit
);
  localparam int CW = COORD_WIDTH;
  typedef logic signed [CW-1:0] crd_t;

  logic [4*CW-1:0] wdata, rdata;
  logic            in_range;
  logic [AW-1:0]   waddr;

  assign in_range = ({26'd0, wr_index} < 32'(MAX_WALLS));
  assign waddr    = AW'(wr_index);
  assign wdata = {CW'(signed'(ax)), CW'(signed'(ay)), CW'(signed'(bx)), CW'(signed'(by))};

  hwcc_ram #(.WIDTH(4*CW), .DEPTH(MAX_WALLS)) u_ram (
    .clk   (clk),
    .we    (wr_en && in_range),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  crd_t l, r, b, t;
  crd_t pxw, pyw, hw;
  assign pxw = CW'(signed'(px));
  assign pyw = CW'(signed'(py));
  assign hw  = CW'({1'b0, half});

  always_ff @(posedge clk) begin
    if (cmd.load_query) begin
      l <= pxw - hw;
      r <= pxw + hw;
      b <= pyw - hw;
      t <= pyw + hw;
    end
  end

  crd_t x0, y0, x1, y1;
  assign x0 = rdata[4*CW-1:3*CW];
  assign y0 = rdata[3*CW-1:2*CW];
  assign x1 = rdata[2*CW-1:CW];
  assign y1 = rdata[CW-1:0];

  // Segment under test: box edge and wall side, each as two end points.
  crd_t pxa, pya, pxb, pyb, qxa, qya, qxb, qyb;
  always_comb begin
    case (test_sel[1:0])
      2'd0: begin pxa = l; pya = b; pxb = l; pyb = t; end
      2'd1: begin pxa = r; pya = b; pxb = r; pyb = t; end
      2'd2: begin pxa = l; pya = b; pxb = r; pyb = b; end
      default: begin pxa = l; pya = t; pxb = r; pyb = t; end
    endcase
    case (test_sel[3:2])
      2'd0: begin qxa = x0; qya = y0; qxb = x0; qyb = y1; end
      2'd1: begin qxa = x0; qya = y1; qxb = x1; qyb = y1; end
      2'd2: begin qxa = x1; qya = y1; qxb = x1; qyb = y0; end
      default: begin qxa = x1; qya = y0; qxb = x0; qyb = y0; end
    endcase
  end

  logic ph, pv, qh, qv;
  crd_t hxa, hxb, hy, vx, vya, vyb;
  logic use_pq, seg_cross;
  assign ph = (pya == pyb) && (pxa != pxb);
  assign pv = (pxa == pxb) && (pya != pyb);
  assign qh = (qya == qyb) && (qxa != qxb);
  assign qv = (qxa == qxb) && (qya != qyb);
  assign use_pq = ph && qv;

  always_comb begin
    if (use_pq) begin
      hxa = pxa; hxb = pxb; hy = pya; vx = qxa; vya = qya; vyb = qyb;
    end else begin
      hxa = qxa; hxb = qxb; hy = qya; vx = pxa; vya = pya; vyb = pyb;
    end
    seg_cross = ((ph && qv) || (pv && qh)) &&
                (((vx >= hxa) && (vx <= hxb)) || ((vx >= hxb) && (vx <= hxa))) &&
                (((hy >= vya) && (hy <= vyb)) || ((hy >= vyb) && (hy <= vya)));
  end

  assign hit = cmd.test_step && seg_cross;
endmodule

@@ sv/hwcc_ctrl.sv @@
// Controller: sequences one wall read and sixteen segment tests per wall.
// Depends on hwcc_pkg.
module hwcc_ctrl
  import hwcc_pkg::*;
#(
  parameter int MAX_WALLS = MAX_WALLS_DEF,
  localparam int AW       = (MAX_WALLS > 1) ? $clog2(MAX_WALLS) : 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               opcode,
  input  logic [COUNT_W-1:0] wall_count,
  input  logic               hit,
  output logic               busy,
  output logic               wr_en,
  output hwcc_cmd_t          cmd,
  output logic [AW-1:0]      rd_addr,
  output logic [3:0]         test_sel,
  output logic               done,
  output logic               free_flag
);
  typedef enum logic [1:0] {S_IDLE, S_READ, S_TEST} state_t;
  state_t state;
  logic [12:0] n, wall;
  logic        free_acc;
  logic        accept;

  assign accept = start && !busy;
  assign wr_en  = accept && (opcode == OP_WRITE);
  assign busy   = (state != S_IDLE);
  assign cmd.load_query = accept && (opcode == OP_QUERY);
  assign cmd.test_step  = (state == S_TEST);
  assign rd_addr = AW'(wall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      done      <= 1'b0;
      free_flag <= 1'b1;
      free_acc  <= 1'b1;
      n         <= '0;
      wall      <= '0;
      test_sel  <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (cmd.load_query) begin
            n <= ({6'd0, wall_count} < 13'(MAX_WALLS)) ? {6'd0, wall_count}
                                                          : 13'(MAX_WALLS);
            wall     <= '0;
            free_acc <= 1'b1;
            test_sel <= '0;
            state    <= S_READ;
          end
        end
        S_READ: begin
          // RAM data for this wall lands at the end of this cycle.
          if (wall >= n) begin
            done      <= 1'b1;
            free_flag <= free_acc;
            state     <= S_IDLE;
          end else begin
            test_sel <= '0;
            state    <= S_TEST;
          end
        end
        S_TEST: begin
          if (hit) begin
            free_acc <= 1'b0;
          end
          if (test_sel == 4'd15) begin
            wall  <= wall + 13'd1;
            state <= S_READ;
          end else begin
            test_sel <= test_sel + 4'd1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

@@ sv/hitbox_wall_collision_check.sv @@
// Hitbox wall collision check, top level.
// A write is taken while idle. A query reads min(wall_count, MAX_WALLS) walls:
// one registered table read and sixteen segment tests per wall, one test a cycle
// while testing, in one compare unit. One item at a time; busy is high while busy.
// Synchronous active-high reset initializes the control and the config registers;
// the wall table holds no reset value. The result strobe cannot be stalled.
module hitbox_wall_collision_check
  import hwcc_pkg::*;
#(
  parameter int MAX_WALLS   = MAX_WALLS_DEF,
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic                      opcode,
  input  logic [5:0]                wall_index,
  input  logic signed [FIELD_W-1:0] corner_a_x,
  input  logic signed [FIELD_W-1:0] corner_a_y,
  input  logic signed [FIELD_W-1:0] corner_b_x,
  input  logic signed [FIELD_W-1:0] corner_b_y,
  input  logic signed [FIELD_W-1:0] pos_x,
  input  logic signed [FIELD_W-1:0] pos_y,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_W-1:0]          cfg_data,
  output logic                      result_valid,
  output logic                      position_free
);
  localparam int AW = (MAX_WALLS > 1) ? $clog2(MAX_WALLS) : 1;

  logic [HALF_W-1:0]  hitbox_half;
  logic [COUNT_W-1:0] wall_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      hitbox_half <= HALF_RESET;
      wall_count  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HITBOX_HALF: hitbox_half <= cfg_data[HALF_W-1:0];
        REG_WALL_COUNT:  wall_count  <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  hwcc_cmd_t     cmd;
  logic          wr_en, hit;
  logic [AW-1:0] rd_addr;
  logic [3:0]    test_sel;

  hwcc_ctrl #(.MAX_WALLS(MAX_WALLS)) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .opcode     (opcode),
    .wall_count (wall_count),
    .hit        (hit),
    .busy       (busy),
    .wr_en      (wr_en),
    .cmd        (cmd),
    .rd_addr    (rd_addr),
    .test_sel   (test_sel),
    .done       (result_valid),
    .free_flag  (position_free)
  );

  hwcc_datapath #(.MAX_WALLS(MAX_WALLS), .COORD_WIDTH(COORD_WIDTH)) u_dp (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_index (wall_index),
    .ax       (corner_a_x),
    .ay       (corner_a_y),
    .bx       (corner_b_x),
    .by       (corner_b_y),
    .px       (pos_x),
    .py       (pos_y),
    .half     (hitbox_half),
    .cmd      (cmd),
    .rd_addr  (rd_addr),
    .test_sel (test_sel),
    .hit      (hit)
  );
endmodule

@@ test/tb.sv @@
// Self-checking testbench for hitbox_wall_collision_check: wall writes and
// hitbox queries, with a predictor for the free flag. Depends on hwcc_pkg and the block.
module tb;
  import hwcc_pkg::*;

  typedef struct {
    logic              op;
    logic [5:0]        idx;
    logic signed [30:0] ax, ay, bx, by, px, py;
  } beat_t;

  typedef struct {
    longint x0, y0, x1, y1;
  } wall_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic opcode = OP_WRITE;
  logic [5:0] wall_index = '0;
  logic signed [FIELD_W-1:0] corner_a_x = '0, corner_a_y = '0, corner_b_x = '0, corner_b_y = '0;
  logic signed [FIELD_W-1:0] pos_x = '0, pos_y = '0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_HITBOX_HALF;
  logic [CFG_W-1:0] cfg_data = '0;
  logic result_valid;
  logic position_free;

  hitbox_wall_collision_check DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  beat_t  pending_beats[$];
  logic   expected_free[$];
  wall_t  walls[64];
  longint half_side = 16384;
  int     walls_tested = 0;
  int     mismatches = 0;
  int     accepted = 0;
  bit     calm = 1'b0;
  logic   busy_q = 1'b0;

  // Only axis-aligned segments exist, so a cross is a horizontal meeting a vertical.
  function automatic bit hv_meet(longint hxa, longint hxb, longint hy,
                                 longint vx, longint vya, longint vyb);
    longint hl, hh, vl, vh;
    hl = hxa < hxb ? hxa : hxb;  hh = hxa < hxb ? hxb : hxa;
    vl = vya < vyb ? vya : vyb;  vh = vya < vyb ? vyb : vya;
    return hxa != hxb && vya != vyb && vx >= hl && vx <= hh && hy >= vl && hy <= vh;
  endfunction

  function automatic bit predict_free(longint px, longint py);
    longint l, r, b, t;
    wall_t e;
    int n;
    bit hit;
    l = px - half_side; r = px + half_side; b = py - half_side; t = py + half_side;
    n = walls_tested > 64 ? 64 : walls_tested;
    hit = 1'b0;
    for (int w = 0; w < n; w++) begin
      e = walls[w];
      // Vertical box edges against horizontal wall sides, then the converse.
      for (int k = 0; k < 2; k++) begin
        longint ex = k ? r : l;
        if (hv_meet(e.x0, e.x1, e.y1, ex, b, t)) hit = 1'b1;
        if (hv_meet(e.x0, e.x1, e.y0, ex, b, t)) hit = 1'b1;
        if (hv_meet(l, r, k ? t : b, e.x0, e.y0, e.y1)) hit = 1'b1;
        if (hv_meet(l, r, k ? t : b, e.x1, e.y0, e.y1)) hit = 1'b1;
      end
    end
    return !hit;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we = 1'b1; cfg_index = idx; cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == REG_HITBOX_HALF) half_side = longint'(val);
    else walls_tested = int'(val[COUNT_W-1:0]);
  endtask

  task automatic wait_idle();
    while (pending_beats.size() != 0 || expected_free.size() != 0 || busy || start)
      @(negedge clk);
    repeat (2200) @(negedge clk);
  endtask

  function automatic logic signed [30:0] rnd_coord(int span);
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return {1'b1, 30'd0};
    if (pick == 1) return {1'b0, {30{1'b1}}};
    if (pick < 4) return 31'($urandom());
    return 31'($signed(31'($urandom_range(0, 2 * span))) - span);
  endfunction

  function automatic beat_t make_wall(int slot, int span);
    beat_t it;
    it.op = OP_WRITE; it.idx = 6'(slot);
    it.ax = rnd_coord(span); it.ay = rnd_coord(span);
    it.bx = $urandom_range(0, 3) == 0 ? it.ax : rnd_coord(span);
    it.by = $urandom_range(0, 3) == 0 ? it.ay : rnd_coord(span);
    it.px = 31'($urandom()); it.py = 31'($urandom());
    return it;
  endfunction

  function automatic beat_t make_query(int span);
    beat_t it;
    it.op = OP_QUERY; it.idx = 6'($urandom());
    it.ax = 31'($urandom()); it.ay = 31'($urandom());
    it.bx = 31'($urandom()); it.by = 31'($urandom());
    it.px = rnd_coord(span); it.py = rnd_coord(span);
    return it;
  endfunction

  // Driver: presents queued beats at falling edges, with random gaps unless calm.
  always @(negedge clk) begin
    if (!rst) begin
      if (start && !busy_q) begin
        void'(pending_beats.pop_front());
      end
      if (pending_beats.size() != 0 && (calm || $urandom_range(0, 99) >= 28)) begin
        start <= 1'b1;
        opcode <= pending_beats[0].op;      wall_index <= pending_beats[0].idx;
        corner_a_x <= pending_beats[0].ax;  corner_a_y <= pending_beats[0].ay;
        corner_b_x <= pending_beats[0].bx;  corner_b_y <= pending_beats[0].by;
        pos_x <= pending_beats[0].px;       pos_y <= pending_beats[0].py;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Acceptance is judged at the rising edge; the predictor runs there too.
  always @(posedge clk) begin
    busy_q <= busy;
    if (!rst && start && !busy) begin
      accepted++;
      if (opcode == OP_WRITE) begin
        walls[wall_index] = '{corner_a_x, corner_a_y, corner_b_x, corner_b_y};
      end else begin
        expected_free.push_back(predict_free(pos_x, pos_y));
      end
    end
  end

  // Monitor: every strobed beat is matched with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && result_valid) begin
      if (expected_free.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat, free=%0b", position_free);
      end else begin
        if (position_free !== expected_free[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("free flag: expected %0b, got %0b", expected_free[0], position_free);
        end
        void'(expected_free.pop_front());
      end
    end
  end

  initial begin
    beat_t it;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: fill all slots, then edge cases of the box and the walls.
    for (int s = 0; s < 64; s++) begin
      it = make_wall(s, 1 << 20);
      if (s == 0) begin
        it.ax = -31'sd65536; it.ay = -31'sd65536; it.bx = 31'sd65536; it.by = 31'sd65536;
      end
      if (s == 1) begin
        it.ax = {1'b1, 30'd0}; it.bx = {1'b0, {30{1'b1}}}; it.ay = '0; it.by = '0;
      end
      pending_beats.push_back(it);
    end
    wait_idle();
    write_reg(REG_WALL_COUNT, CFG_W'(2));
    it = make_query(0); it.px = 31'sd81920; it.py = '0; pending_beats.push_back(it);
    it.px = 31'sd81921; pending_beats.push_back(it);
    it.px = '0; it.py = '0; pending_beats.push_back(it);
    it.px = {1'b1, 30'd0}; it.py = {1'b0, {30{1'b1}}}; pending_beats.push_back(it);
    it.px = {1'b0, {30{1'b1}}}; it.py = {1'b1, 30'd0}; pending_beats.push_back(it);
    wait_idle();
    write_reg(REG_HITBOX_HALF, '0);
    it.px = 31'sd65536; it.py = '0; pending_beats.push_back(it);
    wait_idle();
    write_reg(REG_HITBOX_HALF, {CFG_W{1'b1}});
    write_reg(REG_WALL_COUNT, CFG_W'(64));
    pending_beats.push_back(make_query(1 << 20));
    wait_idle();
    write_reg(REG_WALL_COUNT, '0);
    pending_beats.push_back(make_query(1 << 20));
    wait_idle();

    // Random phases over several settings; mostly small tables keep queries short.
    for (int ph = 0; ph < 8; ph++) begin
      int span;
      span = 1 << $urandom_range(12, 26);
      calm = (ph == 3);
      write_reg(REG_HITBOX_HALF,
                ph == 5 ? {CFG_W{1'b1}} : CFG_W'($urandom_range(0, span)));
      write_reg(REG_WALL_COUNT, ph == 7 ? CFG_W'(64) : CFG_W'($urandom_range(0, 8)));
      for (int k = 0; k < 64; k++) begin
        if ($urandom_range(0, 2) == 0)
          pending_beats.push_back(make_wall(int'($urandom_range(0, 63)), span));
        else pending_beats.push_back(make_query(span));
      end
      wait_idle();
    end

    if (mismatches == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end

  initial begin
    #40000000;
    $display("tb: done, errors");
    $finish;
  end
endmodule

@@ hitbox_wall_collision_check.f @@
sv/hwcc_pkg.sv
sv/hwcc_ram.sv
sv/hwcc_datapath.sv
sv/hwcc_ctrl.sv
sv/hitbox_wall_collision_check.sv
test/tb.sv
